[src/brq_pkg.sv]
// brq_pkg: transaction types, action and status codes of the broadcast ring queue
// used by brq_slot_ctrl, the top level and the testbench; depends on nothing
`timescale 1ns / 1ps

package brq_pkg;

  localparam int CNT_W = 32;

  // action codes
  localparam logic [2:0] ACT_SUBSCRIBE   = 3'd0;
  localparam logic [2:0] ACT_UNSUBSCRIBE = 3'd1;
  localparam logic [2:0] ACT_PRODUCE     = 3'd2;
  localparam logic [2:0] ACT_CONSUME     = 3'd3;
  localparam logic [2:0] ACT_READ_DROPS  = 3'd4;
  localparam logic [2:0] ACT_TAKE_DROPS  = 3'd5;
  localparam logic [2:0] ACT_TAKE_STATS  = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LIMIT  = 3'd1;
  localparam logic [2:0] ST_NOCONS = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_REJECT = 3'd4;
  localparam logic [2:0] ST_NOSLOT = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  consumer_slot;
    logic [31:0] payload;
    logic        reject;
  } brq_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       assigned_slot;
    logic [31:0]      read_data;
    logic [CNT_W-1:0] drop_count;
    logic [CNT_W-1:0] delivered_count;
  } brq_out_t;

  // result of one transaction before the entry read data joins it
  typedef struct packed {
    logic [2:0]       status;
    logic [2:0]       assigned_slot;
    logic [CNT_W-1:0] drop_count;
    logic [CNT_W-1:0] delivered_count;
    logic             has_data;
  } brq_res_t;

endpackage

[src/brq_entry_ram.sv]
// brq_entry_ram: single-port entry store of the ring, registered read data
// depends on nothing
`timescale 1ns / 1ps

module brq_entry_ram #(
  parameter int DEPTH = 64,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DW-1:0]            wdata,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // one access per cycle, read data valid the cycle after
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/brq_slot_ctrl.sv]
// brq_slot_ctrl: write pointer, per-slot read pointers and counters, action decode
// uses brq_pkg; drives the entry memory access of each transaction
`timescale 1ns / 1ps

module brq_slot_ctrl
  import brq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 64,
  parameter int NUM_CONSUMERS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  brq_in_t                        item,
  output brq_res_t                       res,
  output logic                           mem_we,
  output logic                           mem_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0] mem_addr
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CW   = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;
  localparam int CNTW = $clog2(NUM_CONSUMERS + 1);

  logic [AW-1:0]            wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]            rd_idx_r [NUM_CONSUMERS];
  logic [AW-1:0]            rd_idx_nxt [NUM_CONSUMERS];
  logic [NUM_CONSUMERS-1:0] active_r, active_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         dc_r [NUM_CONSUMERS];
  logic [CNT_W-1:0]         dc_nxt [NUM_CONSUMERS];
  logic [CNT_W-1:0]         du_r [NUM_CONSUMERS];
  logic [CNT_W-1:0]         du_nxt [NUM_CONSUMERS];
  logic [CNT_W-1:0]         dl_r [NUM_CONSUMERS];
  logic [CNT_W-1:0]         dl_nxt [NUM_CONSUMERS];

  logic [CW-1:0] slot_idx;
  logic [CW-1:0] free_idx;
  logic          in_range;
  logic          sel_ok;
  logic          full;
  logic [AW-1:0] wr_next;
  logic [AW-1:0] wr_skip;
  logic [AW-1:0] rd_cur;
  logic [AW-1:0] rd_next;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // addressed slot and lowest free slot
  assign in_range = {29'd0, item.consumer_slot} < 32'(NUM_CONSUMERS);
  assign slot_idx = CW'(item.consumer_slot);
  assign sel_ok   = in_range && active_r[slot_idx];
  assign full     = (cnt_r == CNTW'(NUM_CONSUMERS));

  always_comb begin
    free_idx = '0;
    for (int s = NUM_CONSUMERS - 1; s >= 0; s--) begin
      if (!active_r[s]) begin
        free_idx = CW'(s);
      end
    end
  end

  // ring positions
  assign wr_next = ring_next(wr_idx_r);
  assign wr_skip = ring_next(wr_next);
  assign rd_cur  = in_range ? rd_idx_r[slot_idx] : '0;
  assign rd_next = ring_next(rd_cur);

  // action decode and next state
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    dc_nxt     = dc_r;
    du_nxt     = du_r;
    dl_nxt     = dl_r;
    res        = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = wr_next;
    unique case (item.action)
      ACT_SUBSCRIBE: begin
        if (full) begin
          res.status = ST_LIMIT;
        end else begin
          active_nxt[free_idx] = 1'b1;
          rd_idx_nxt[free_idx] = wr_idx_r;
          dc_nxt[free_idx]     = '0;
          du_nxt[free_idx]     = '0;
          dl_nxt[free_idx]     = '0;
          cnt_nxt              = cnt_r + 1'b1;
          res.assigned_slot    = 3'(free_idx);
        end
      end
      ACT_UNSUBSCRIBE: begin
        if (!sel_ok) begin
          res.status = ST_NOSLOT;
        end else begin
          active_nxt[slot_idx] = 1'b0;
          dc_nxt[slot_idx]     = '0;
          du_nxt[slot_idx]     = '0;
          dl_nxt[slot_idx]     = '0;
          cnt_nxt              = cnt_r - 1'b1;
        end
      end
      ACT_PRODUCE: begin
        if (cnt_r == '0) begin
          res.status = ST_NOCONS;
        end else begin
          // slots sitting on the next write position get pushed past it
          for (int s = 0; s < NUM_CONSUMERS; s++) begin
            if (active_r[s] && rd_idx_r[s] == wr_next) begin
              rd_idx_nxt[s] = wr_skip;
              dc_nxt[s]     = dc_r[s] + 1'b1;
              du_nxt[s]     = du_r[s] + 1'b1;
            end
          end
          if (item.reject) begin
            res.status = ST_REJECT;
          end else begin
            mem_we     = go;
            wr_idx_nxt = wr_next;
          end
        end
      end
      ACT_CONSUME: begin
        if (!sel_ok) begin
          res.status = ST_NOSLOT;
        end else if (rd_cur == wr_idx_r) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re       = go;
          mem_addr     = rd_next;
          res.has_data = 1'b1;
          if (item.reject) begin
            res.status = ST_REJECT;
          end else begin
            rd_idx_nxt[slot_idx] = rd_next;
            dl_nxt[slot_idx]     = dl_r[slot_idx] + 1'b1;
            if (rd_next == wr_idx_r) begin
              dc_nxt[slot_idx] = '0;
            end
          end
        end
      end
      ACT_READ_DROPS: begin
        if (in_range) begin
          res.drop_count = dc_r[slot_idx];
        end
      end
      ACT_TAKE_DROPS: begin
        if (in_range) begin
          res.drop_count   = du_r[slot_idx];
          du_nxt[slot_idx] = '0;
        end
      end
      ACT_TAKE_STATS: begin
        if (in_range) begin
          res.drop_count      = du_r[slot_idx];
          res.delivered_count = dl_r[slot_idx];
          du_nxt[slot_idx]    = '0;
          dl_nxt[slot_idx]    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // state update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      active_r <= '0;
      cnt_r    <= '0;
      for (int s = 0; s < NUM_CONSUMERS; s++) begin
        rd_idx_r[s] <= '0;
        dc_r[s]     <= '0;
        du_r[s]     <= '0;
        dl_r[s]     <= '0;
      end
    end else if (go) begin
      wr_idx_r <= wr_idx_nxt;
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
      dc_r     <= dc_nxt;
      du_r     <= du_nxt;
      dl_r     <= dl_nxt;
    end
  end

  // active count tracks the active flags
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNTW'($countones(active_r)))
    else $error("active count out of step with active slots");

  // one memory access per transaction
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("entry memory written and read together");

  // a committed produce moves the write pointer onto the written entry
  a_wr_advance: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> wr_idx_r == $past(mem_addr))
    else $error("write pointer not on last written entry");

endmodule

[src/broadcast_ring_queue_drop_slow.sv]
// broadcast_ring_queue_drop_slow: top level, input handshake, read stage, output register
// uses brq_pkg, brq_slot_ctrl and brq_entry_ram
`timescale 1ns / 1ps

// Broadcast ring queue with one writer and up to NUM_CONSUMERS readers, each with
// its own read pointer; a reader that falls a full ring behind is skipped ahead and
// counted as a drop. Every transaction gives exactly one result. A new transaction is
// taken only once the read stage is empty: it is decoded and applied to the pointers and
// counters in the cycle it is accepted, and its result then sits in a read stage where
// the entry memory's registered read data joins it. An output register holds the
// result until taken, so one further transaction is accepted while a result waits.
// Entries are not cleared after reset and need no clearing pass.
module broadcast_ring_queue_drop_slow
  import brq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 64,
  parameter int NUM_CONSUMERS = 8,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  brq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output brq_out_t out_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int DW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;

  logic          go;
  brq_res_t      res;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [DW-1:0] rdata;

  logic     s1_valid_r;
  brq_res_t s1_res_r;
  logic     s1_move;
  logic     out_valid_r;
  brq_out_t out_data_r;

  assign in_ready = !s1_valid_r;
  assign go       = in_valid && in_ready;
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);

  brq_slot_ctrl #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .NUM_CONSUMERS (NUM_CONSUMERS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .item     (in_data),
    .res      (res),
    .mem_we   (mem_we),
    .mem_re   (mem_re),
    .mem_addr (mem_addr)
  );

  brq_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (in_data.payload[DW-1:0]),
    .rdata (rdata)
  );

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (go) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (go) begin
      s1_res_r <= res;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload, entry data joins here
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.status          <= s1_res_r.status;
      out_data_r.assigned_slot   <= s1_res_r.assigned_slot;
      out_data_r.read_data       <= s1_res_r.has_data ? 32'(rdata) : 32'd0;
      out_data_r.drop_count      <= s1_res_r.drop_count;
      out_data_r.delivered_count <= s1_res_r.delivered_count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every accepted transaction lands in the read stage
  a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> s1_valid_r)
    else $error("accepted transaction missing from read stage");

  // no new transaction while the read stage is occupied
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !in_ready)
    else $error("input accepted while read stage busy");

  // a waiting result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("waiting result changed or dropped");

endmodule

[bench/testbench.sv]
// testbench: self-checking bench for broadcast_ring_queue_drop_slow, directed table then random
// transactions checked against an in-bench ring queue predictor; depends on brq_pkg and the dut
`timescale 1ns / 1ps

module testbench;
  import brq_pkg::*;

  localparam int QDEPTH = 64;
  localparam int NCONS = 8;
  localparam int RAND_ITEMS = 1025;
  localparam int CALM_ITEMS = 120;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 16;

  // action code the block ignores
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct {
    brq_in_t  item;
    bit       typed;
    brq_out_t want;
  } stim_row_t;

  localparam brq_out_t NO_RESULT = '0;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  brq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  brq_out_t out_data;

  // predictor state
  logic [31:0] ring_mem [QDEPTH];
  bit          ring_written [QDEPTH];
  logic [5:0]  wr_ptr = '0;
  logic [5:0]  rd_ptr [NCONS];
  bit          sub_on [NCONS];
  int unsigned sub_total = 0;
  logic [31:0] drop_run [NCONS];
  logic [31:0] drop_unrep [NCONS];
  logic [31:0] deliv_unrep [NCONS];

  brq_out_t    expected_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  // action mix per random phase: balanced, flood, drain, churn (percent, codes 0..7)
  int unsigned action_mix [4][8] = '{
    '{8, 4, 35, 35, 5, 5, 6, 2},
    '{3, 2, 70, 12, 4, 4, 4, 1},
    '{3, 2, 15, 65, 5, 5, 4, 1},
    '{14, 10, 30, 30, 5, 5, 5, 1}
  };

  broadcast_ring_queue_drop_slow dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < NCONS; s++) begin
      rd_ptr[s] = '0;
      sub_on[s] = 1'b0;
      drop_run[s] = '0;
      drop_unrep[s] = '0;
      deliv_unrep[s] = '0;
    end
    for (int e = 0; e < QDEPTH; e++) begin
      ring_mem[e] = '0;
      ring_written[e] = 1'b0;
    end
  end

  // one line per mismatch, counted
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // ring queue behavior for one accepted transaction
  task automatic ring_predict(input brq_in_t t, output brq_out_t r);
    logic [5:0] nxt;
    logic [5:0] skp;
    int unsigned s;
    bit found;
    r = '0;
    r.status = ST_OK;
    s = {29'd0, t.consumer_slot};
    found = 1'b0;
    case (t.action)
      ACT_SUBSCRIBE: begin
        if (sub_total >= NCONS) begin
          r.status = ST_LIMIT;
        end else begin
          for (int k = 0; k < NCONS; k++) begin
            if (!found && !sub_on[k]) begin
              found = 1'b1;
              sub_on[k] = 1'b1;
              rd_ptr[k] = wr_ptr;
              drop_run[k] = '0;
              drop_unrep[k] = '0;
              deliv_unrep[k] = '0;
              sub_total++;
              r.assigned_slot = k[2:0];
            end
          end
        end
      end
      ACT_UNSUBSCRIBE: begin
        if (!sub_on[s]) begin
          r.status = ST_NOSLOT;
        end else begin
          sub_on[s] = 1'b0;
          drop_run[s] = '0;
          drop_unrep[s] = '0;
          deliv_unrep[s] = '0;
          if (sub_total > 0) sub_total--;
        end
      end
      ACT_PRODUCE: begin
        if (sub_total == 0) begin
          r.status = ST_NOCONS;
        end else begin
          nxt = wr_ptr + 6'd1;
          skp = nxt + 6'd1;
          // readers a full ring behind are pushed past the slot about to be written
          for (int k = 0; k < NCONS; k++) begin
            if (sub_on[k] && rd_ptr[k] == nxt) begin
              rd_ptr[k] = skp;
              drop_run[k] = drop_run[k] + 32'd1;
              drop_unrep[k] = drop_unrep[k] + 32'd1;
            end
          end
          if (t.reject) begin
            r.status = ST_REJECT;
          end else begin
            ring_mem[nxt] = t.payload;
            ring_written[nxt] = 1'b1;
            wr_ptr = nxt;
          end
        end
      end
      ACT_CONSUME: begin
        if (!sub_on[s]) begin
          r.status = ST_NOSLOT;
        end else if (rd_ptr[s] == wr_ptr) begin
          r.status = ST_EMPTY;
        end else begin
          nxt = rd_ptr[s] + 6'd1;
          r.read_data = ring_mem[nxt];
          if (t.reject) begin
            r.status = ST_REJECT;
          end else begin
            rd_ptr[s] = nxt;
            deliv_unrep[s] = deliv_unrep[s] + 32'd1;
            if (nxt == wr_ptr) drop_run[s] = '0;
          end
        end
      end
      ACT_READ_DROPS: begin
        r.drop_count = drop_run[s];
      end
      ACT_TAKE_DROPS: begin
        r.drop_count = drop_unrep[s];
        drop_unrep[s] = '0;
      end
      ACT_TAKE_STATS: begin
        r.drop_count = drop_unrep[s];
        r.delivered_count = deliv_unrep[s];
        drop_unrep[s] = '0;
        deliv_unrep[s] = '0;
      end
      default: begin
      end
    endcase
  endtask

  // mostly a subscribed slot, sometimes any slot
  function automatic logic [2:0] pick_slot();
    int unsigned cand [$];
    for (int k = 0; k < NCONS; k++) begin
      if (sub_on[k]) cand.push_back(k);
    end
    if (cand.size() > 0 && $urandom_range(0, 9) != 0) begin
      return 3'(cand[$urandom_range(0, cand.size() - 1)]);
    end
    return 3'($urandom_range(0, NCONS - 1));
  endfunction

  // random transaction shaped by the current phase
  task automatic pick_random_item(input int phase, output brq_in_t t);
    int unsigned roll;
    int unsigned acc;
    logic [2:0] act;
    roll = $urandom_range(0, 99);
    acc = 0;
    act = ACT_UNUSED;
    for (int a = 7; a >= 0; a--) begin
      acc += action_mix[phase][7 - a];
      if (roll < acc && act == ACT_UNUSED && (7 - a) != 7) act = 3'(7 - a);
      if (roll < acc) break;
    end
    // keep the queue populated so produce and consume get past the first checks
    if (sub_total == 0 && $urandom_range(0, 9) < 7) act = ACT_SUBSCRIBE;
    t.action = act;
    t.consumer_slot = pick_slot();
    t.payload = $urandom();
    t.reject = ($urandom_range(0, 5) == 0);
    // never consume an entry the writer has not filled yet
    if (act == ACT_CONSUME && sub_on[t.consumer_slot] &&
        rd_ptr[t.consumer_slot] != wr_ptr &&
        !ring_written[rd_ptr[t.consumer_slot] + 6'd1]) begin
      t.action = ACT_READ_DROPS;
    end
  endtask

  // present one transaction, wait for acceptance, record what must come back
  task automatic drive_txn(input brq_in_t t, input bit typed, input brq_out_t want);
    brq_out_t predicted;
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_predict(t, predicted);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // stimulus: reset, directed table, random phases, drain
  initial begin : stimulus
    brq_in_t item;
    int unsigned counted;
    int phase;

    // directed table: typed results where obvious, predictor elsewhere
    directed_rows.push_back('{brq_in_t'{ACT_PRODUCE, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_NOCONS, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_CONSUME, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_NOSLOT, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_UNSUBSCRIBE, 3'd7, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_NOSLOT, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_READ_DROPS, 3'd3, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_SUBSCRIBE, 3'd5, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_CONSUME, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_EMPTY, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_PRODUCE, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_PRODUCE, 3'd0, 32'hFFFF_FFFF, 1'b1}, 1'b1,
                              brq_out_t'{ST_REJECT, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_PRODUCE, 3'd0, 32'hFFFF_FFFF, 1'b0}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_CONSUME, 3'd0, 32'h0, 1'b1}, 1'b1,
                              brq_out_t'{ST_REJECT, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_CONSUME, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_CONSUME, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_OK, 3'd0, 32'hFFFF_FFFF, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_CONSUME, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_EMPTY, 3'd0, 32'd0, 32'd0, 32'd0}});
    // fill every slot, then one too many
    for (int k = 1; k < NCONS; k++) begin
      directed_rows.push_back('{brq_in_t'{ACT_SUBSCRIBE, 3'(k), 32'h0, 1'b0}, 1'b0,
                                NO_RESULT});
    end
    directed_rows.push_back('{brq_in_t'{ACT_SUBSCRIBE, 3'd0, 32'h0, 1'b0}, 1'b1,
                              brq_out_t'{ST_LIMIT, 3'd0, 32'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{brq_in_t'{ACT_TAKE_STATS, 3'd0, 32'h0, 1'b0}, 1'b0, NO_RESULT});
    directed_rows.push_back('{brq_in_t'{ACT_UNSUBSCRIBE, 3'd3, 32'h0, 1'b0}, 1'b0, NO_RESULT});
    directed_rows.push_back('{brq_in_t'{ACT_SUBSCRIBE, 3'd0, 32'h0, 1'b0}, 1'b0, NO_RESULT});
    directed_rows.push_back('{brq_in_t'{ACT_TAKE_DROPS, 3'd7, 32'h0, 1'b0}, 1'b0, NO_RESULT});

    // synchronous reset, released on a falling clock edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_txn(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases; ignored codes do not count toward the total
    counted = 0;
    while (counted < RAND_ITEMS) begin
      phase = (counted * 4) / RAND_ITEMS;
      calm = (counted >= RAND_ITEMS - CALM_ITEMS);
      pick_random_item(phase, item);
      drive_txn(item, 1'b0, NO_RESULT);
      if (item.action != ACT_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side backpressure in random bursts, none near the end
  initial begin : sink_pacing
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    brq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing expected, status", 32'(out_data.status), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.assigned_slot !== want.assigned_slot)
          flag_mismatch("assigned_slot", 32'(out_data.assigned_slot), 32'(want.assigned_slot));
        if (out_data.read_data !== want.read_data)
          flag_mismatch("read_data", out_data.read_data, want.read_data);
        if (out_data.drop_count !== want.drop_count)
          flag_mismatch("drop_count", out_data.drop_count, want.drop_count);
        if (out_data.delivered_count !== want.delivered_count)
          flag_mismatch("delivered_count", out_data.delivered_count, want.delivered_count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
